// ===== rtl/mbrtu_pkg.sv =====
// shared types and constants of the modbus rtu frame receiver
`default_nettype none

package mbrtu_pkg;

   // input operations
   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_IDLE    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // modbus function codes
   localparam logic [7:0] FUNC_READ_REGS  = 8'd3;
   localparam logic [7:0] FUNC_WRITE_REG  = 8'd6;
   localparam logic [7:0] FUNC_WRITE_REGS = 8'd16;

   // command kinds
   localparam logic [1:0] CMD_READ_REGS  = 2'd0;
   localparam logic [1:0] CMD_WRITE_REG  = 2'd1;
   localparam logic [1:0] CMD_WRITE_REGS = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_SLAVE_ADDR  = 2'd0;
   localparam logic [1:0] CSR_BCAST_ADDR  = 2'd1;
   localparam logic [1:0] CSR_SERIES_ADDR = 2'd2;
   localparam logic [1:0] CSR_SERIES_VAL  = 2'd3;

   localparam logic [7:0] SLAVE_ADDR_RESET = 8'd1;
   localparam logic [7:0] BCAST_ADDR_RESET = 8'd0;

   // byte positions inside a request
   localparam int unsigned POS_ADDR      = 0;
   localparam int unsigned POS_FUNC      = 1;
   localparam int unsigned POS_START_HI  = 2;
   localparam int unsigned POS_START_LO  = 3;
   localparam int unsigned POS_COUNT_HI  = 4;
   localparam int unsigned POS_COUNT_LO  = 5;
   localparam int unsigned POS_BYTE_CNT  = 6;
   localparam int unsigned POS_FIXED_END = 7;
   localparam int unsigned POS_DATA      = 7;
   localparam int unsigned MULTI_OVERHEAD = 8;

   // series byte index: 7 + 2 * 16-bit offset
   localparam int unsigned SERIES_IDX_W = 18;
   // end position compare width
   localparam int unsigned END_W = 10;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_index;
      logic       byte_kept;
      logic       frame_done;
      logic [1:0] command;
      logic       series_ok;
      logic       frame_dropped;
      logic       busy_res;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  slave_address;
      logic [7:0]  broadcast_address;
      logic [15:0] series_register_address;
      logic [15:0] expected_series_value;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/mbrtu_if.sv =====
// channel interfaces of the modbus rtu frame receiver
`default_nettype none

interface mbrtu_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface mbrtu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_index;
   logic       byte_kept;
   logic       frame_done;
   logic [1:0] command;
   logic       series_ok;
   logic       frame_dropped;
   logic       busy_res;

   modport source (output valid, output byte_index, output byte_kept, output frame_done,
                   output command, output series_ok, output frame_dropped,
                   output busy_res, input ready);
   modport sink (input valid, input byte_index, input byte_kept, input frame_done,
                 input command, input series_ok, input frame_dropped,
                 input busy_res, output ready);
endinterface

interface mbrtu_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/modbus_rtu_frame_receiver_top.sv =====
// Modbus RTU request receiver: tracks frame length and addressing of received bytes.
// Each transaction on req_bus gives exactly one transaction on rsp_bus. One transaction
// is taken per clock cycle unless rsp_bus stalls; a transaction passes an input register
// and then a result register, which offers its result on rsp_bus. req_bus.ready
// follows rsp_bus.ready in the same cycle when both registers are full. The configuration
// port is always ready and should be written only while no transaction is in flight.
`default_nettype none

module modbus_rtu_frame_receiver_top
   import mbrtu_pkg::*;
#(
   parameter int unsigned BUFFER_SIZE = 256
)
(
   input wire logic  clock,
   input wire logic  reset,
   mbrtu_req_if.sink req_bus,
   mbrtu_rsp_if.source rsp_bus,
   mbrtu_csr_if.sink csr_bus
);

   cfg_type cfg;
   logic    req_valid_ff;
   logic    req_valid_in;
   req_type req_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    advance;
   logic    req_take;

   assign csr_bus.ready = 1'b1;

   mbrtu_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.wdata),
      .cfg      (cfg)
   );

   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign req_valid_in  = req_bus.ready ? req_bus.valid : req_valid_ff;
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_bus.ready);

   mbrtu_deframe #(
      .BUFFER_SIZE (BUFFER_SIZE)
   ) u_deframe (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (req_data_ff),
      .cfg    (cfg),
      .result (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_data_ff.op      <= req_bus.op;
         req_data_ff.rx_byte <= req_bus.rx_byte;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.byte_index    = rsp_data_ff.byte_index;
   assign rsp_bus.byte_kept     = rsp_data_ff.byte_kept;
   assign rsp_bus.frame_done    = rsp_data_ff.frame_done;
   assign rsp_bus.command       = rsp_data_ff.command;
   assign rsp_bus.series_ok     = rsp_data_ff.series_ok;
   assign rsp_bus.frame_dropped = rsp_data_ff.frame_dropped;
   assign rsp_bus.busy_res      = rsp_data_ff.busy_res;

endmodule

`default_nettype wire

// ===== rtl/mbrtu_csr.sv =====
// configuration register bank
`default_nettype none

module mbrtu_csr
   import mbrtu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_en,
   input  wire logic [1:0]  wr_index,
   input  wire logic [15:0] wr_data,
   output      cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_SLAVE_ADDR:  cfg_in.slave_address           = wr_data[7:0];
            CSR_BCAST_ADDR:  cfg_in.broadcast_address       = wr_data[7:0];
            CSR_SERIES_ADDR: cfg_in.series_register_address = wr_data;
            CSR_SERIES_VAL:  cfg_in.expected_series_value   = wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address           <= SLAVE_ADDR_RESET;
         cfg_ff.broadcast_address       <= BCAST_ADDR_RESET;
         cfg_ff.series_register_address <= '0;
         cfg_ff.expected_series_value   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/mbrtu_deframe.sv =====
// frame tracking state and per-transaction next-state logic
`default_nettype none

module mbrtu_deframe
   import mbrtu_pkg::*;
#(
   parameter int unsigned BUFFER_SIZE = 256
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output      rsp_type result
);

   localparam int unsigned PW = $clog2(BUFFER_SIZE + 1);

   typedef struct packed {
      logic [PW-1:0] position;
      logic          complete_flag;
      logic [1:0]    command_kind;
      logic [7:0]    data_byte_count;
      logic [15:0]   start_register;
      logic [15:0]   register_count;
      logic [15:0]   captured_series;
   } frame_type;

   frame_type                 frame_ff;
   frame_type                 frame_in;
   frame_type                 base;
   logic [PW-1:0]             p;
   logic [PW-1:0]             p_next;
   logic                      handled;
   logic [15:0]               series_offset;
   logic                      series_covered;
   logic [SERIES_IDX_W-1:0]   series_idx;
   logic [SERIES_IDX_W-1:0]   p_wide;

   // where the protected value sits in the frame, zero if not covered
   assign series_offset  = cfg.series_register_address - frame_ff.start_register;
   assign series_covered = (frame_ff.register_count != '0)
                        && (cfg.series_register_address >= frame_ff.start_register)
                        && (series_offset < frame_ff.register_count);
   assign series_idx     = series_covered
                         ? SERIES_IDX_W'(POS_DATA) + {1'b0, series_offset, 1'b0}
                         : '0;

   always_comb begin
      frame_in = frame_ff;
      base     = frame_ff;
      handled  = 1'b0;
      p        = '0;
      p_next   = '0;
      p_wide   = '0;
      result   = '0;
      unique case (item.op)
         OP_BYTE: begin
            result.byte_kept = 1'b1;
            if (frame_ff.position >= PW'(BUFFER_SIZE)) begin
               base                 = '0;
               result.frame_dropped = 1'b1;
            end
            p                 = base.position;
            p_next            = p + 1'b1;
            p_wide            = SERIES_IDX_W'(p);
            result.byte_index = 8'(p);
            frame_in          = base;
            if (p == PW'(POS_ADDR)) begin
               if (item.rx_byte != cfg.slave_address
                   && item.rx_byte != cfg.broadcast_address) begin
                  frame_in         = '0;
                  result.byte_kept = 1'b0;
                  handled          = 1'b1;
               end
            end else if (p == PW'(POS_FUNC)) begin
               unique case (item.rx_byte)
                  FUNC_READ_REGS:  frame_in.command_kind = CMD_READ_REGS;
                  FUNC_WRITE_REG:  frame_in.command_kind = CMD_WRITE_REG;
                  FUNC_WRITE_REGS: frame_in.command_kind = CMD_WRITE_REGS;
                  default: begin
                     frame_in             = '0;
                     result.byte_kept     = 1'b0;
                     result.frame_dropped = 1'b1;
                     handled              = 1'b1;
                  end
               endcase
            end else begin
               if (p == PW'(POS_START_HI)) frame_in.start_register[15:8] = item.rx_byte;
               if (p == PW'(POS_START_LO)) frame_in.start_register[7:0]  = item.rx_byte;
               if (p == PW'(POS_COUNT_HI)) frame_in.register_count[15:8] = item.rx_byte;
               if (p == PW'(POS_COUNT_LO)) frame_in.register_count[7:0]  = item.rx_byte;
               if (p == PW'(POS_BYTE_CNT)) frame_in.data_byte_count      = item.rx_byte;

               if (base.command_kind == CMD_READ_REGS || base.command_kind == CMD_WRITE_REG) begin
                  if (p == PW'(POS_FIXED_END)) begin
                     frame_in.complete_flag = 1'b1;
                     frame_in.position      = p_next;
                     result.frame_done      = 1'b1;
                     result.series_ok       = 1'b1;
                     handled                = 1'b1;
                  end
               end else if (base.command_kind == CMD_WRITE_REGS) begin
                  if (p == PW'(POS_BYTE_CNT)
                      && END_W'(item.rx_byte) + END_W'(MULTI_OVERHEAD) >= END_W'(BUFFER_SIZE)) begin
                     frame_in             = '0;
                     result.byte_kept     = 1'b0;
                     result.frame_dropped = 1'b1;
                     handled              = 1'b1;
                  end else if (p >= PW'(POS_DATA)) begin
                     if (!base.complete_flag && series_idx != '0) begin
                        if (p_wide == series_idx) begin
                           frame_in.captured_series[15:8] = item.rx_byte;
                        end else if (p_wide == series_idx + 1'b1) begin
                           frame_in.captured_series[7:0] = item.rx_byte;
                        end
                     end
                     if (END_W'(p) == END_W'(base.data_byte_count) + END_W'(MULTI_OVERHEAD)) begin
                        frame_in.complete_flag = 1'b1;
                        frame_in.position      = p_next;
                        result.frame_done      = 1'b1;
                        handled                = 1'b1;
                        priority if (series_idx == '0) begin
                           result.series_ok = 1'b1;
                        end else if (series_idx >= p_wide) begin
                           result.series_ok = 1'b0;
                        end else begin
                           result.series_ok = (frame_in.captured_series
                                               == cfg.expected_series_value);
                        end
                     end
                  end
               end else begin
                  frame_in             = '0;
                  result.byte_kept     = 1'b0;
                  result.frame_dropped = 1'b1;
                  handled              = 1'b1;
               end
            end
            if (!handled) begin
               frame_in.position = p_next;
               if (p_next >= PW'(BUFFER_SIZE)) begin
                  frame_in             = '0;
                  result.byte_kept     = 1'b0;
                  result.frame_dropped = 1'b1;
               end
            end
         end
         OP_IDLE: begin
            if (frame_ff.position != '0 && !frame_ff.complete_flag) begin
               frame_in             = '0;
               result.frame_dropped = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (frame_ff.complete_flag) begin
               frame_in = '0;
            end
         end
         default: frame_in = frame_ff;
      endcase
      result.command  = frame_in.command_kind;
      result.busy_res = (frame_in.position != '0) || frame_in.complete_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else if (step) begin
         frame_ff <= frame_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mbrtu_checker.sv =====
// port-level checks of the modbus rtu frame receiver and their binding
`default_nettype none

module mbrtu_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_byte_index,
   input wire logic       rsp_byte_kept,
   input wire logic       rsp_frame_done,
   input wire logic       rsp_series_ok,
   input wire logic       rsp_frame_dropped,
   input wire logic       rsp_busy_res
);

   logic rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_index)
         && $stable(rsp_frame_done) && $stable(rsp_busy_res))
      else $error("stalled result changed");

   // a completing byte belongs to a frame that is now held
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_frame_done |-> rsp_byte_kept && rsp_busy_res && !rsp_frame_dropped)
      else $error("frame done without held frame");

   // series check only reported with completion
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_frame_done |-> !rsp_series_ok)
      else $error("series ok without frame done");

   // a kept byte leaves a frame in progress, a drop without a kept byte leaves none
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (!rsp_byte_kept || rsp_busy_res)
         && (!(rsp_frame_dropped && !rsp_byte_kept) || !rsp_busy_res))
      else $error("busy flag inconsistent with kept or dropped byte");

endmodule

bind modbus_rtu_frame_receiver_top mbrtu_checker u_mbrtu_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_byte_index    (rsp_bus.byte_index),
   .rsp_byte_kept     (rsp_bus.byte_kept),
   .rsp_frame_done    (rsp_bus.frame_done),
   .rsp_series_ok     (rsp_bus.series_ok),
   .rsp_frame_dropped (rsp_bus.frame_dropped),
   .rsp_busy_res      (rsp_bus.busy_res)
);

`default_nettype wire
